FILE: sv/m4i_pkg.sv
package m4i_pkg;

   // Matrix geometry and result indexing.
   localparam int N_ENTRIES = 16;
   localparam int IDX_W     = 4;
   localparam logic [IDX_W-1:0] LAST_INDEX = 4'd15;

   // Command queue between the front and the compute engine.
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = CMD_PTR_W + 1;

   // Threshold register.
   localparam int THR_W = 31;
   localparam logic [THR_W-1:0] DET_THRESHOLD_RESET = 31'd1;

   // Six signed triple products make up one 3x3 minor.
   localparam int TERM_W = 3;
   localparam logic [TERM_W-1:0] TERM_LAST = 3'd5;

   // Head of the command queue as seen by the engine.
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] index;
      logic             last;
   } cmd_ctrl_type;

   // Request to the quotient unit.
   typedef struct packed {
      logic start;
      logic negative;
   } div_req_type;

   // Width of the rounded numerator and of the shifted divisor in the quotient unit.
   function automatic int m4i_num_width(input int ew, input int fb);
      int a;
      int b;
      a = 2 * ew + 2 * fb;
      b = 4 * ew;
      return ((a > b) ? a : b) + 2;
   endfunction

   // The k-th of the four lines once the line excl has been struck out.
   function automatic logic [1:0] m4i_skip(input logic [1:0] k, input logic [1:0] excl);
      return (k >= excl) ? k + 2'd1 : k;
   endfunction

   // Column of the minor used in row p by triple product term.
   function automatic logic [1:0] m4i_perm(input logic [TERM_W-1:0] term,
                                           input logic [1:0] p);
      logic [5:0] row;
      unique case (term)
         3'd0:    row = {2'd2, 2'd1, 2'd0};
         3'd1:    row = {2'd1, 2'd2, 2'd0};
         3'd2:    row = {2'd2, 2'd0, 2'd1};
         3'd3:    row = {2'd0, 2'd2, 2'd1};
         3'd4:    row = {2'd1, 2'd0, 2'd2};
         3'd5:    row = {2'd0, 2'd1, 2'd2};
         default: row = '0;
      endcase
      unique case (p)
         2'd0:    return row[1:0];
         2'd1:    return row[3:2];
         default: return row[5:4];
      endcase
   endfunction

   // Odd permutations enter the minor with a minus sign.
   function automatic logic m4i_term_neg(input logic [TERM_W-1:0] term);
      return (term == 3'd1) || (term == 3'd2) || (term == 3'd5);
   endfunction

   // Store address of minor element (p, q) for the cofactor at position pos.
   function automatic logic [IDX_W-1:0] m4i_elem_addr(input logic [IDX_W-1:0] pos,
                                                      input logic [1:0] p,
                                                      input logic [1:0] q);
      logic [1:0] r;
      logic [1:0] c;
      r = m4i_skip(p, pos[3:2]);
      c = m4i_skip(q, pos[1:0]);
      return {c, r};
   endfunction

   // Diagonal positions of the identity.
   function automatic logic m4i_is_diag(input logic [IDX_W-1:0] pos);
      return (pos == 4'd0) || (pos == 4'd5) || (pos == 4'd10) || (pos == 4'd15);
   endfunction

endpackage

FILE: sv/m4i_cmd_queue.sv
module m4i_cmd_queue
   import m4i_pkg::*;
#(
   parameter int ELEMENT_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [ELEMENT_WIDTH-1:0] push_value,
   input  logic [IDX_W-1:0]         push_index,
   input  logic                     push_last,
   output cmd_ctrl_type             head_ctrl,
   output logic [ELEMENT_WIDTH-1:0] head_value,
   input  logic                     pop
);

   logic [ELEMENT_WIDTH-1:0] value_ff [CMD_DEPTH];
   logic [IDX_W-1:0]         index_ff [CMD_DEPTH];
   logic                     last_ff  [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]     wr_ptr_ff;
   logic [CMD_PTR_W-1:0]     rd_ptr_ff;
   logic [CMD_CNT_W-1:0]     count_ff;
   logic                     push;

   // A transaction is taken whenever a slot is free.
   assign busy = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign push = start && !busy;

   assign head_ctrl.valid = (count_ff != '0);
   assign head_ctrl.index = index_ff[rd_ptr_ff];
   assign head_ctrl.last  = last_ff[rd_ptr_ff];
   assign head_value      = value_ff[rd_ptr_ff];

   // Queue slots carry payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         value_ff[wr_ptr_ff] <= push_value;
         index_ff[wr_ptr_ff] <= push_index;
         last_ff[wr_ptr_ff]  <= push_last;
      end
   end

   // Pointers and fill level; the depth is a power of two so pointers wrap.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

FILE: sv/m4i_divider.sv
module m4i_divider
   import m4i_pkg::*;
#(
   parameter int ELEMENT_WIDTH = 32,
   parameter int FRAC_BITS     = 16
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  div_req_type                                        div_req,
   input  logic [m4i_num_width(ELEMENT_WIDTH, FRAC_BITS)-1:0] div_num,
   input  logic [m4i_num_width(ELEMENT_WIDTH, FRAC_BITS)-1:0] div_den,
   output logic                                               div_done,
   output logic signed [ELEMENT_WIDTH-1:0]                    div_quot
);

   localparam int EW    = ELEMENT_WIDTH;
   localparam int XW    = m4i_num_width(ELEMENT_WIDTH, FRAC_BITS);
   localparam int CNT_W = $clog2(EW + 1);

   localparam logic [EW-1:0] MIN_VAL = {1'b1, {(EW-1){1'b0}}};
   localparam logic [EW-1:0] MAX_VAL = {1'b0, {(EW-1){1'b1}}};

   logic              run_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [XW-1:0]     rem_ff;
   logic [XW-1:0]     dsh_ff;
   logic [EW-1:0]     quo_ff;
   logic              ovf_ff;
   logic              neg_ff;
   logic              fits;
   logic [XW-1:0]     rem_in;

   // Restoring step: one quotient bit per cycle against a divisor shifted down.
   assign fits   = (rem_ff >= dsh_ff);
   assign rem_in = fits ? rem_ff - dsh_ff : rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(EW);
            rem_ff <= div_num;
            dsh_ff <= div_den << (EW - 1);
            quo_ff <= '0;
            // A quotient of 2^EW or more saturates whatever its sign.
            ovf_ff <= (div_num >= (div_den << EW));
            neg_ff <= div_req.negative;
         end else if (run_ff) begin
            rem_ff <= rem_in;
            dsh_ff <= dsh_ff >> 1;
            quo_ff <= {quo_ff[EW-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_done = done_ff;

   // Apply the sign and saturate to the element range.
   always_comb begin
      if (ovf_ff) begin
         div_quot = neg_ff ? MIN_VAL : MAX_VAL;
      end else if (neg_ff) begin
         div_quot = (quo_ff > MIN_VAL) ? MIN_VAL : (~quo_ff + 1'b1);
      end else begin
         div_quot = quo_ff[EW-1] ? MAX_VAL : quo_ff;
      end
   end

endmodule

FILE: sv/m4i_engine.sv
module m4i_engine
   import m4i_pkg::*;
#(
   parameter int ELEMENT_WIDTH = 32,
   parameter int FRAC_BITS     = 16
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  cmd_ctrl_type                                       cmd_ctrl,
   input  logic [ELEMENT_WIDTH-1:0]                           cmd_value,
   output logic                                               cmd_pop,
   input  logic [THR_W-1:0]                                   det_threshold,
   output div_req_type                                        div_req,
   output logic [m4i_num_width(ELEMENT_WIDTH, FRAC_BITS)-1:0] div_num,
   output logic [m4i_num_width(ELEMENT_WIDTH, FRAC_BITS)-1:0] div_den,
   input  logic                                               div_done,
   input  logic signed [ELEMENT_WIDTH-1:0]                    div_quot,
   output logic                                               rsp_strobe,
   output logic signed [ELEMENT_WIDTH-1:0]                    rsp_result_value,
   output logic [IDX_W-1:0]                                   rsp_result_index,
   output logic                                               rsp_singular,
   output logic                                               rsp_last_result
);

   localparam int EW = ELEMENT_WIDTH;
   localparam int PW = 2 * EW + 1;
   localparam int CW = 2 * EW;
   localparam int AW = 3 * EW + 3;
   localparam int SW = (AW > THR_W + FRAC_BITS) ? AW : THR_W + FRAC_BITS;
   localparam int XW = m4i_num_width(ELEMENT_WIDTH, FRAC_BITS);

   typedef enum logic [3:0] {
      S_IDLE, S_T0, S_T1, S_T2, S_T3, S_T4, S_CF,
      S_D0, S_D1, S_D2, S_D3, S_SING, S_ORD, S_OST, S_OWAIT, S_OSING
   } state_type;

   state_type state_ff;

   // Stores: matrix with per-entry valid bits, cofactors without.
   logic [EW-1:0]        mat_mem [N_ENTRIES];
   logic [N_ENTRIES-1:0] mat_valid_ff;
   logic [EW-1:0]        rd_a_ff;
   logic [EW-1:0]        rd_b_ff;
   logic [CW-1:0]        cof_mem [N_ENTRIES];
   logic [CW-1:0]        cof_rd_ff;

   logic [IDX_W-1:0]     addr_a;
   logic [IDX_W-1:0]     addr_b;
   logic [IDX_W-1:0]     cof_addr;

   logic [IDX_W-1:0]     pos_ff;
   logic [TERM_W-1:0]    term_ff;
   logic [1:0]           k_ff;

   logic signed [EW:0]   mul_x;
   logic signed [EW-1:0] mul_y;
   logic signed [PW-1:0] prod_in;
   logic signed [PW-1:0] prod_ff;
   logic signed [EW-1:0] hi_ff;

   logic signed [AW-1:0] prod_ext;
   logic signed [AW-1:0] addend;
   logic                 acc_sub;
   logic signed [AW-1:0] acc_in;
   logic signed [AW-1:0] acc_ff;

   logic signed [AW-1:0] cof_signed;
   logic signed [AW-1:0] cof_shr;
   logic [AW-CW:0]       cof_upper;
   logic [CW-1:0]        cof_sat;

   logic [AW-1:0]        acc_mag;
   logic [SW-1:0]        thr_scaled;
   logic                 sing_in;
   logic                 sing_ff;
   logic [AW-1:0]        det_mag_ff;
   logic                 det_neg_ff;

   logic                 cof_neg;
   logic [CW-1:0]        cof_mag;
   logic [EW-1:0]        id_val;

   logic                 rsp_strobe_ff;
   logic signed [EW-1:0] rsp_value_ff;
   logic [IDX_W-1:0]     rsp_index_ff;
   logic                 rsp_singular_ff;
   logic                 rsp_last_ff;

   // Elements are drained from the queue only between runs.
   assign cmd_pop = (state_ff == S_IDLE) && cmd_ctrl.valid;

   // Store read addresses for the current step.
   always_comb begin
      addr_a   = '0;
      addr_b   = '0;
      cof_addr = pos_ff;
      unique case (state_ff)
         S_T0, S_T1, S_T2, S_T3, S_T4: begin
            addr_a = m4i_elem_addr(pos_ff, 2'd0, m4i_perm(term_ff, 2'd0));
            addr_b = (state_ff == S_T0) ?
                     m4i_elem_addr(pos_ff, 2'd1, m4i_perm(term_ff, 2'd1)) :
                     m4i_elem_addr(pos_ff, 2'd2, m4i_perm(term_ff, 2'd2));
         end
         S_D0, S_D1, S_D2, S_D3: begin
            addr_a   = {2'b00, k_ff};
            cof_addr = {k_ff, 2'b00};
         end
         default: begin
            addr_a   = '0;
            addr_b   = '0;
            cof_addr = pos_ff;
         end
      endcase
   end

   // Matrix store: written from the queue, two registered read ports.
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         mat_mem[cmd_ctrl.index] <= cmd_value;
      end
      rd_a_ff <= mat_valid_ff[addr_a] ? mat_mem[addr_a] : '0;
      rd_b_ff <= mat_valid_ff[addr_b] ? mat_mem[addr_b] : '0;
   end

   // Cofactor store: written as each cofactor completes, one registered read port.
   always_ff @(posedge clock) begin
      if (state_ff == S_CF) begin
         cof_mem[pos_ff] <= cof_sat;
      end
      cof_rd_ff <= cof_mem[cof_addr];
   end

   // Shared multiplier; wide operands go through as an unsigned low half and a
   // signed high half.
   always_comb begin
      mul_x = '0;
      mul_y = '0;
      unique case (state_ff)
         S_T1: begin
            mul_x = {rd_a_ff[EW-1], rd_a_ff};
            mul_y = rd_b_ff;
         end
         S_T2: begin
            mul_x = {1'b0, prod_ff[EW-1:0]};
            mul_y = rd_b_ff;
         end
         S_T3: begin
            mul_x = {hi_ff[EW-1], hi_ff};
            mul_y = rd_b_ff;
         end
         S_D1: begin
            mul_x = {1'b0, cof_rd_ff[EW-1:0]};
            mul_y = rd_a_ff;
         end
         S_D2: begin
            mul_x = {cof_rd_ff[CW-1], cof_rd_ff[CW-1:EW]};
            mul_y = rd_a_ff;
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   assign prod_in = mul_x * mul_y;

   // Accumulator: the high partial product enters one half-word up.
   assign prod_ext = AW'(prod_ff);
   assign addend   = ((state_ff == S_T4) || (state_ff == S_D3)) ? (prod_ext <<< EW) : prod_ext;
   assign acc_sub  = ((state_ff == S_T3) || (state_ff == S_T4)) && m4i_term_neg(term_ff);
   assign acc_in   = acc_sub ? acc_ff - addend : acc_ff + addend;

   // Cofactor sign, scaling back to the double-width format and saturation.
   assign cof_signed = (pos_ff[2] ^ pos_ff[0]) ? -acc_ff : acc_ff;
   assign cof_shr    = cof_signed >>> (2 * FRAC_BITS);
   assign cof_upper  = cof_shr[AW-1:CW-1];
   always_comb begin
      if ((&cof_upper) || !(|cof_upper)) begin
         cof_sat = cof_shr[CW-1:0];
      end else if (cof_shr[AW-1]) begin
         cof_sat = {1'b1, {(CW-1){1'b0}}};
      end else begin
         cof_sat = {1'b0, {(CW-1){1'b1}}};
      end
   end

   // Singular test against the threshold scaled to the determinant format.
   assign acc_mag    = acc_ff[AW-1] ? -acc_ff : acc_ff;
   assign thr_scaled = SW'(det_threshold) << FRAC_BITS;
   assign sing_in    = (SW'(acc_mag) <= thr_scaled);

   // Rounded numerator for the quotient unit.
   assign cof_neg       = cof_rd_ff[CW-1];
   assign cof_mag       = cof_neg ? (~cof_rd_ff + 1'b1) : cof_rd_ff;
   assign div_num       = (XW'(cof_mag) << (2 * FRAC_BITS)) + XW'(det_mag_ff >> 1);
   assign div_den       = XW'(det_mag_ff);
   assign div_req.start    = (state_ff == S_OST);
   assign div_req.negative = cof_neg ^ det_neg_ff;

   assign id_val = m4i_is_diag(pos_ff) ? (EW'(1) << FRAC_BITS) : '0;

   // Sequencer: six triple products per cofactor, four products for the
   // determinant, then one transaction out per position.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mat_valid_ff  <= '0;
         pos_ff        <= '0;
         term_ff       <= '0;
         k_ff          <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         prod_ff       <= prod_in;
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_ctrl.valid) begin
                  mat_valid_ff[cmd_ctrl.index] <= 1'b1;
                  if (cmd_ctrl.last) begin
                     pos_ff   <= '0;
                     term_ff  <= '0;
                     acc_ff   <= '0;
                     state_ff <= S_T0;
                  end
               end
            end
            S_T0: state_ff <= S_T1;
            S_T1: state_ff <= S_T2;
            S_T2: begin
               hi_ff    <= prod_ff[CW-1:EW];
               state_ff <= S_T3;
            end
            S_T3: begin
               acc_ff   <= acc_in;
               state_ff <= S_T4;
            end
            S_T4: begin
               acc_ff <= acc_in;
               if (term_ff == TERM_LAST) begin
                  state_ff <= S_CF;
               end else begin
                  term_ff  <= term_ff + 1'b1;
                  state_ff <= S_T0;
               end
            end
            S_CF: begin
               acc_ff  <= '0;
               term_ff <= '0;
               if (pos_ff == LAST_INDEX) begin
                  k_ff     <= '0;
                  state_ff <= S_D0;
               end else begin
                  pos_ff   <= pos_ff + 1'b1;
                  state_ff <= S_T0;
               end
            end
            S_D0: state_ff <= S_D1;
            S_D1: state_ff <= S_D2;
            S_D2: begin
               acc_ff   <= acc_in;
               state_ff <= S_D3;
            end
            S_D3: begin
               acc_ff <= acc_in;
               if (k_ff == 2'd3) begin
                  state_ff <= S_SING;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_D0;
               end
            end
            S_SING: begin
               sing_ff    <= sing_in;
               det_mag_ff <= acc_mag;
               det_neg_ff <= acc_ff[AW-1];
               pos_ff     <= '0;
               state_ff   <= sing_in ? S_OSING : S_ORD;
            end
            S_ORD: state_ff <= S_OST;
            S_OST: state_ff <= S_OWAIT;
            S_OWAIT: begin
               if (div_done) begin
                  rsp_strobe_ff   <= 1'b1;
                  rsp_value_ff    <= div_quot;
                  rsp_index_ff    <= pos_ff;
                  rsp_singular_ff <= 1'b0;
                  rsp_last_ff     <= (pos_ff == LAST_INDEX);
                  if (pos_ff == LAST_INDEX) begin
                     state_ff <= S_IDLE;
                  end else begin
                     pos_ff   <= pos_ff + 1'b1;
                     state_ff <= S_ORD;
                  end
               end
            end
            S_OSING: begin
               rsp_strobe_ff   <= 1'b1;
               rsp_value_ff    <= id_val;
               rsp_index_ff    <= pos_ff;
               rsp_singular_ff <= sing_ff;
               rsp_last_ff     <= (pos_ff == LAST_INDEX);
               if (pos_ff == LAST_INDEX) begin
                  state_ff <= S_IDLE;
               end else begin
                  pos_ff <= pos_ff + 1'b1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_singular     = rsp_singular_ff;
   assign rsp_last_result  = rsp_last_ff;

endmodule

FILE: sv/matrix4_inverse_core.sv
// Elements are queued one a cycle while busy is low (four-deep queue); the last one starts
// a run of cofactors and then the determinant on one shared multiplier.
// A singular matrix then gives one result a cycle; otherwise each result waits on the
// bit-serial quotient unit. Results cannot be held off.
// Reset (synchronous, active high) empties the queue, zeroes the matrix and sets threshold 1.
module matrix4_inverse_core
   import m4i_pkg::*;
#(
   parameter int ELEMENT_WIDTH = 32,
   parameter int FRAC_BITS     = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [ELEMENT_WIDTH-1:0] req_element_value,
   input  logic [IDX_W-1:0]                req_element_index,
   input  logic                            req_load_done,
   input  logic                            csr_write_enable,
   input  logic [THR_W-1:0]                csr_write_data,
   output logic                            rsp_strobe,
   output logic signed [ELEMENT_WIDTH-1:0] rsp_result_value,
   output logic [IDX_W-1:0]                rsp_result_index,
   output logic                            rsp_singular,
   output logic                            rsp_last_result
);

   localparam int XW = m4i_num_width(ELEMENT_WIDTH, FRAC_BITS);

   logic [THR_W-1:0]         thr_ff;
   cmd_ctrl_type             head_ctrl;
   logic [ELEMENT_WIDTH-1:0] head_value;
   logic                     cmd_pop;
   div_req_type              div_req;
   logic [XW-1:0]            div_num;
   logic [XW-1:0]            div_den;
   logic                     div_done;
   logic signed [ELEMENT_WIDTH-1:0] div_quot;

   // Threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= DET_THRESHOLD_RESET;
      end else if (csr_write_enable) begin
         thr_ff <= csr_write_data;
      end
   end

   // Front: takes transactions into the command queue.
   m4i_cmd_queue #(
      .ELEMENT_WIDTH(ELEMENT_WIDTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .push_value(req_element_value),
      .push_index(req_element_index),
      .push_last (req_load_done),
      .head_ctrl (head_ctrl),
      .head_value(head_value),
      .pop       (cmd_pop)
   );

   // Back: stores elements and runs the inversion.
   m4i_engine #(
      .ELEMENT_WIDTH(ELEMENT_WIDTH),
      .FRAC_BITS    (FRAC_BITS)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .cmd_ctrl        (head_ctrl),
      .cmd_value       (head_value),
      .cmd_pop         (cmd_pop),
      .det_threshold   (thr_ff),
      .div_req         (div_req),
      .div_num         (div_num),
      .div_den         (div_den),
      .div_done        (div_done),
      .div_quot        (div_quot),
      .rsp_strobe      (rsp_strobe),
      .rsp_result_value(rsp_result_value),
      .rsp_result_index(rsp_result_index),
      .rsp_singular    (rsp_singular),
      .rsp_last_result (rsp_last_result)
   );

   // Rounded, saturating quotient unit.
   m4i_divider #(
      .ELEMENT_WIDTH(ELEMENT_WIDTH),
      .FRAC_BITS    (FRAC_BITS)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_num (div_num),
      .div_den (div_den),
      .div_done(div_done),
      .div_quot(div_quot)
   );

endmodule

FILE: sv/m4i_checker.sv
module m4i_checker
   import m4i_pkg::*;
#(
   parameter int ELEMENT_WIDTH = 32,
   parameter int FRAC_BITS     = 16
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            busy,
   input logic                            rsp_strobe,
   input logic signed [ELEMENT_WIDTH-1:0] rsp_result_value,
   input logic [IDX_W-1:0]                rsp_result_index,
   input logic                            rsp_singular,
   input logic                            rsp_last_result
);

   localparam logic [ELEMENT_WIDTH-1:0] ONE_VAL = ELEMENT_WIDTH'(1) << FRAC_BITS;

   // Reset leaves the block empty and silent.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !busy && !rsp_strobe)
      else $error("block not idle after reset");

   // The final transaction of a run carries the last position; the flag only counts
   // while the strobe marks a transaction.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_result |-> (rsp_result_index == LAST_INDEX))
      else $error("last flag away from the final position");

   // A singular run returns the identity.
   a_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_singular |->
         (((rsp_result_index == 4'd0) || (rsp_result_index == 4'd5) ||
           (rsp_result_index == 4'd10) || (rsp_result_index == 4'd15)) ?
          (rsp_result_value == ONE_VAL) : (rsp_result_value == '0)))
      else $error("singular result is not the identity");

   // A singular run streams its positions on consecutive cycles.
   a_sing_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_singular && !rsp_last_result |=>
         rsp_strobe && rsp_singular &&
         (rsp_result_index == $past(rsp_result_index) + 4'd1))
      else $error("singular results not back to back");

endmodule

bind matrix4_inverse_core m4i_checker #(
   .ELEMENT_WIDTH(ELEMENT_WIDTH),
   .FRAC_BITS    (FRAC_BITS)
) u_m4i_checker (
   .clock            (clock),
   .reset            (reset),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_result_value (rsp_result_value),
   .rsp_result_index (rsp_result_index),
   .rsp_singular     (rsp_singular),
   .rsp_last_result  (rsp_last_result)
);
